// ===== sv/utf8_validate_line_break_marker_assert.svh =====
// assertion macros for the utf8 validation and line break marker
`ifndef UTF8_VALIDATE_LINE_BREAK_MARKER_ASSERT_SVH
`define UTF8_VALIDATE_LINE_BREAK_MARKER_ASSERT_SVH

// checked only while reset is low
`define UVLB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define UVLB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/uvlb_pkg.sv =====
// shared types and byte constants for the utf8 validation and line break marker
package uvlb_pkg;

   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] NEL_LEAD     = 8'hC2;
   localparam logic [7:0] NEL_TAIL     = 8'h85;
   localparam logic [7:0] LSPS_LEAD    = 8'hE2;
   localparam logic [7:0] LSPS_MID     = 8'h80;
   localparam logic [7:0] LS_TAIL      = 8'hA8;
   localparam logic [7:0] PS_TAIL      = 8'hA9;
   localparam logic [7:0] LEAD_LO      = 8'hC0;
   localparam logic [7:0] LEAD2_LO     = 8'hC2;
   localparam logic [7:0] LEAD2_HI     = 8'hDF;
   localparam logic [7:0] LEAD3_LO     = 8'hE0;
   localparam logic [7:0] LEAD3_HI     = 8'hEF;
   localparam logic [7:0] LEAD4_LO     = 8'hF0;
   localparam logic [7:0] LEAD4_HI     = 8'hF4;
   localparam logic [7:0] SUFFIX_LO    = 8'h80;
   localparam logic [7:0] SUFFIX_HI    = 8'hBF;
   localparam logic [7:0] LEAD_E0      = 8'hE0;
   localparam logic [7:0] LEAD_ED      = 8'hED;
   localparam logic [7:0] LEAD_F0      = 8'hF0;
   localparam logic [7:0] LEAD_F4      = 8'hF4;
   localparam logic [7:0] E0_BAD_HI    = 8'h9F;
   localparam logic [7:0] ED_BAD_LO    = 8'hA0;
   localparam logic [7:0] F0_BAD_HI    = 8'h8F;
   localparam logic [7:0] F4_BAD_LO    = 8'h90;

   typedef struct packed {
      logic nonfinal;
      logic brk;
   } class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       nonfinal_mark;
      logic       break_mark;
      logic       final_result;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

endpackage

// ===== sv/uvlb_classify.sv =====
// classifies one byte against the three previous bytes
module uvlb_classify
   import uvlb_pkg::*;
(
   input  logic [7:0] cur_byte,
   input  logic [7:0] prev1,
   input  logic [7:0] prev2,
   input  logic [7:0] prev3,
   output class_type  result
);

   logic lead, legal, suffix;
   logic s22, s32, s33, s42, s43, s44, scope;
   logic bad_second, invalid;

   always_comb begin
      lead   = cur_byte >= LEAD_LO;
      legal  = (cur_byte >= LEAD2_LO && cur_byte <= LEAD2_HI) ||
               (cur_byte >= LEAD3_LO && cur_byte <= LEAD3_HI) ||
               (cur_byte >= LEAD4_LO && cur_byte <= LEAD4_HI);
      suffix = cur_byte >= SUFFIX_LO && cur_byte <= SUFFIX_HI;

      s22 = prev1 >= LEAD2_LO && prev1 <= LEAD2_HI;
      s32 = prev1 >= LEAD3_LO && prev1 <= LEAD3_HI;
      s33 = prev2 >= LEAD3_LO && prev2 <= LEAD3_HI;
      s42 = prev1 >= LEAD4_LO && prev1 <= LEAD4_HI;
      s43 = prev2 >= LEAD4_LO && prev2 <= LEAD4_HI;
      s44 = prev3 >= LEAD4_LO && prev3 <= LEAD4_HI;
      scope = s22 || s32 || s33 || s42 || s43 || s44;

      // overlong or out of range second byte
      bad_second = (prev1 == LEAD_E0 && cur_byte >= SUFFIX_LO && cur_byte <= E0_BAD_HI) ||
                   (prev1 == LEAD_ED && cur_byte >= ED_BAD_LO && cur_byte <= SUFFIX_HI) ||
                   (prev1 == LEAD_F0 && cur_byte >= SUFFIX_LO && cur_byte <= F0_BAD_HI) ||
                   (prev1 == LEAD_F4 && cur_byte >= F4_BAD_LO && cur_byte <= SUFFIX_HI);

      invalid = (lead != legal) || (scope != suffix) || bad_second;

      result.nonfinal = (lead || s32 || s42 || s43) && !invalid;
      result.brk      = (cur_byte >= CHAR_LF && cur_byte <= CHAR_CR) ||
                        (prev1 == NEL_LEAD && cur_byte == NEL_TAIL) ||
                        (prev2 == LSPS_LEAD && prev1 == LSPS_MID &&
                         (cur_byte == LS_TAIL || cur_byte == PS_TAIL));
   end

endmodule

// ===== sv/uvlb_rsp_fifo.sv =====
// result queue: takes up to two results per cycle, hands out one while rsp_tready is high
module uvlb_rsp_fifo
   import uvlb_pkg::*;
#(
   parameter int RSP_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         room_for_two,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // [7:0] byte_out
   output logic [1:0]   rsp_tuser,   // [0] nonfinal_mark, [1] break_mark
   output logic         rsp_tlast    // final_result
);

   localparam int PtrW = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CntW = $clog2(RSP_DEPTH + 1);

   rsp_item_type mem [RSP_DEPTH];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_nxt;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   function automatic logic [PtrW-1:0] nxt_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(RSP_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      pop          = rsp_tvalid && rsp_tready;
      wr_ptr_nxt   = nxt_ptr(wr_ptr_ff);
      wr_ptr_in    = wr_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_nxt;
         2'd2:    wr_ptr_in = nxt_ptr(wr_ptr_nxt);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in    = pop ? nxt_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in     = count_ff + CntW'(push.count) - CntW'(pop);
      rsp_tvalid   = count_ff != '0;
      room_for_two = count_ff <= CntW'(RSP_DEPTH - 2);
      rsp_tdata    = mem[rd_ptr_ff].data_byte;
      rsp_tuser    = {mem[rd_ptr_ff].break_mark, mem[rd_ptr_ff].nonfinal_mark};
      rsp_tlast    = mem[rd_ptr_ff].final_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_nxt] <= push.second;
      end
   end

endmodule

// ===== sv/utf8_validate_line_break_marker.sv =====
// utf8 validation and line break marker, one byte per cycle while the result queue has room
// results: a byte's result enters the result queue when the next byte's transaction is accepted,
//   or with its own transaction when it carries tlast
// throughput: one byte per cycle while the result queue has room for two results, else req_tready is low
// reset: clears the byte history, the held result and the result queue
module utf8_validate_line_break_marker
   import uvlb_pkg::*;
#(
   parameter int RSP_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] byte_out
   output logic [1:0] rsp_tuser,   // [0] nonfinal_mark, [1] break_mark
   output logic       rsp_tlast    // final_result
);

`include "utf8_validate_line_break_marker_assert.svh"

   logic [7:0]   hist0_ff, hist1_ff, hist2_ff, hist0_in, hist1_in, hist2_in;
   logic         held_valid_ff, held_valid_in;
   rsp_item_type held_ff, held_in;
   class_type    cur_class;
   rsp_item_type held_item, cur_item;
   rsp_push_type push;
   logic         accept, crlf, room_for_two;

   uvlb_classify u_classify (
      .cur_byte (req_tdata),
      .prev1    (hist0_ff),
      .prev2    (hist1_ff),
      .prev3    (hist2_ff),
      .result   (cur_class)
   );

   always_comb begin
      req_tready = room_for_two;
      accept     = req_tvalid && req_tready;

      // cr followed by lf joins the pair
      crlf = held_ff.data_byte == CHAR_CR && req_tdata == CHAR_LF;
      held_item               = held_ff;
      held_item.nonfinal_mark = held_ff.nonfinal_mark || crlf;
      held_item.break_mark    = held_ff.break_mark && !crlf;
      held_item.final_result  = 1'b0;

      cur_item.data_byte     = req_tdata;
      cur_item.nonfinal_mark = cur_class.nonfinal;
      cur_item.break_mark    = cur_class.brk;
      cur_item.final_result  = req_tlast;

      push.count  = accept ? ({1'b0, held_valid_ff} + {1'b0, req_tlast}) : 2'd0;
      push.first  = held_valid_ff ? held_item : cur_item;
      push.second = cur_item;

      hist0_in      = hist0_ff;
      hist1_in      = hist1_ff;
      hist2_in      = hist2_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      if (accept) begin
         if (req_tlast) begin
            // stream ends: clear the byte history and the held result as after reset
            hist0_in      = '0;
            hist1_in      = '0;
            hist2_in      = '0;
            held_valid_in = 1'b0;
            held_in       = '0;
         end else begin
            hist0_in      = req_tdata;
            hist1_in      = hist0_ff;
            hist2_in      = hist1_ff;
            held_valid_in = 1'b1;
            held_in       = cur_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff      <= '0;
         hist1_ff      <= '0;
         hist2_ff      <= '0;
         held_valid_ff <= 1'b0;
         held_ff       <= '0;
      end else begin
         hist0_ff      <= hist0_in;
         hist1_ff      <= hist1_in;
         hist2_ff      <= hist2_in;
         held_valid_ff <= held_valid_in;
         held_ff       <= held_in;
      end
   end

   uvlb_rsp_fifo #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

   `UVLB_ASSERT(a_push_shows, (accept && (held_valid_ff || req_tlast)) |=> rsp_tvalid, "queued result not shown")
   `UVLB_ASSERT(a_last_clears, (accept && req_tlast) |=> (!held_valid_ff && hist0_ff == 8'h00), "stream end did not clear state")
   `UVLB_ASSERT(a_first_no_rsp, (accept && !held_valid_ff && !req_tlast && !rsp_tvalid) |=> !rsp_tvalid, "result from nothing")
   `UVLB_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_tvalid && !held_valid_ff), "reset left results")

endmodule

// ===== verif/utf8_validate_line_break_marker_tb.sv =====
// testbench for the utf8 validation and line break marker: directed table, random streams, scoreboard
`timescale 1ns / 100ps

module utf8_validate_line_break_marker_tb;
   import uvlb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 90;
   localparam int DRAIN_CYCLES = 10;
   localparam int DIR_ROWS = 25;

   typedef struct packed {
      logic [7:0] data;
      logic       eot;
      logic       has_exp;
      logic       nf;
      logic       brk;
   } dir_row_type;

   typedef enum int {
      UNIT_ASCII, UNIT_CRLF, UNIT_TWO, UNIT_THREE, UNIT_FOUR, UNIT_BROKEN, UNIT_NOISE
   } unit_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [7:0] data_byte
   logic       req_tlast = 1'b0;  // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] byte_out
   logic [1:0] rsp_tuser;         // [0] nonfinal_mark, [1] break_mark
   logic       rsp_tlast;         // final_result

   // directed rows; nf/brk typed in only where they are obvious
   dir_row_type dir_table [DIR_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'h0D, 1'b0, 1'b1, 1'b1, 1'b0},
      '{8'h0A, 1'b1, 1'b1, 1'b0, 1'b1},
      '{8'h0D, 1'b1, 1'b1, 1'b0, 1'b1},
      '{8'hC2, 1'b0, 1'b1, 1'b1, 1'b0},
      '{8'h85, 1'b1, 1'b1, 1'b0, 1'b1},
      '{8'hE2, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hA9, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hE0, 1'b0, 1'b1, 1'b1, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hED, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hA0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h8F, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hF4, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h90, 1'b1, 1'b1, 1'b0, 1'b0},
      '{8'hF4, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h8F, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hBF, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'hC1, 1'b0, 1'b1, 1'b0, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0}
   };

   // marker model state
   logic [7:0] recent_bytes [3] = '{8'h00, 8'h00, 8'h00};
   logic       held_valid = 1'b0;
   logic [7:0] held_byte = '0;
   logic       held_nf = 1'b0;
   logic       held_brk = 1'b0;
   int         held_row = 0;

   rsp_item_type marks_q [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   int bytes_taken = 0;
   int streams_taken = 0;
   int results_checked = 0;
   int breaks_seen = 0;
   int nonfinal_seen = 0;
   int failures = 0;

   utf8_validate_line_break_marker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic in_span(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
      return b >= lo && b <= hi;
   endfunction

   function automatic class_type classify_byte(logic [7:0] b, logic [7:0] p1,
                                               logic [7:0] p2, logic [7:0] p3);
      class_type  cls;
      logic lead, legal, suffix, s32, s33, s42, s43, s44, scope, bad_second, invalid;
      lead   = in_span(b, LEAD_LO, 8'hFF);
      legal  = in_span(b, LEAD2_LO, LEAD2_HI) || in_span(b, LEAD3_LO, LEAD3_HI) ||
               in_span(b, LEAD4_LO, LEAD4_HI);
      suffix = in_span(b, SUFFIX_LO, SUFFIX_HI);
      s32    = in_span(p1, LEAD3_LO, LEAD3_HI);
      s33    = in_span(p2, LEAD3_LO, LEAD3_HI);
      s42    = in_span(p1, LEAD4_LO, LEAD4_HI);
      s43    = in_span(p2, LEAD4_LO, LEAD4_HI);
      s44    = in_span(p3, LEAD4_LO, LEAD4_HI);
      scope  = in_span(p1, LEAD2_LO, LEAD2_HI) || s32 || s33 || s42 || s43 || s44;
      bad_second = (p1 == LEAD_E0 && in_span(b, SUFFIX_LO, E0_BAD_HI)) ||
                   (p1 == LEAD_ED && in_span(b, ED_BAD_LO, SUFFIX_HI)) ||
                   (p1 == LEAD_F0 && in_span(b, SUFFIX_LO, F0_BAD_HI)) ||
                   (p1 == LEAD_F4 && in_span(b, F4_BAD_LO, SUFFIX_HI));
      invalid = (lead != legal) || (scope != suffix) || bad_second;
      cls.nonfinal = (lead || s32 || s42 || s43) && !invalid;
      cls.brk = in_span(b, CHAR_LF, CHAR_CR) ||
                (p1 == NEL_LEAD && b == NEL_TAIL) ||
                (p2 == LSPS_LEAD && p1 == LSPS_MID && in_span(b, LS_TAIL, PS_TAIL));
      return cls;
   endfunction

   function automatic rsp_item_type apply_typed(rsp_item_type item, int row);
      if (row < DIR_ROWS && dir_table[row].has_exp) begin
         item.nonfinal_mark = dir_table[row].nf;
         item.break_mark = dir_table[row].brk;
      end
      return item;
   endfunction

   // one accepted byte: release the held mark, classify, hold or flush
   task automatic mark_byte(input logic [7:0] b, input logic eot, input int row);
      class_type    cls;
      rsp_item_type item;
      if (held_valid) begin
         item = '{held_byte, held_nf, held_brk, 1'b0};
         if (held_byte == CHAR_CR && b == CHAR_LF) begin
            item.nonfinal_mark = 1'b1;
            item.break_mark = 1'b0;
         end
         marks_q.insert(marks_q.size(), apply_typed(item, held_row));
      end
      cls = classify_byte(b, recent_bytes[0], recent_bytes[1], recent_bytes[2]);
      recent_bytes[2] = recent_bytes[1];
      recent_bytes[1] = recent_bytes[0];
      recent_bytes[0] = b;
      if (eot) begin
         item = '{b, cls.nonfinal, cls.brk, 1'b1};
         marks_q.insert(marks_q.size(), apply_typed(item, row));
         recent_bytes = '{8'h00, 8'h00, 8'h00};
         held_valid = 1'b0;
         held_byte = '0;
         held_nf = 1'b0;
         held_brk = 1'b0;
      end else begin
         held_valid = 1'b1;
         held_byte = b;
         held_nf = cls.nonfinal;
         held_brk = cls.brk;
         held_row = row;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            mark_byte(req_tdata, req_tlast, bytes_taken);
            bytes_taken++;
            if (req_tlast) streams_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (marks_q.size() == 0) begin
               $error("unexpected transaction: byte_out %h", rsp_tdata);
               failures++;
            end else begin
               want = marks_q.pop_front();
               results_checked++;
               if (want.break_mark) breaks_seen++;
               if (want.nonfinal_mark) nonfinal_seen++;
               if (rsp_tdata !== want.data_byte) begin
                  $error("byte_out: expected %h, got %h", want.data_byte, rsp_tdata);
                  failures++;
               end
               if (rsp_tuser[0] !== want.nonfinal_mark) begin
                  $error("nonfinal_mark: expected %b, got %b", want.nonfinal_mark,
                         rsp_tuser[0]);
                  failures++;
               end
               if (rsp_tuser[1] !== want.break_mark) begin
                  $error("break_mark: expected %b, got %b", want.break_mark, rsp_tuser[1]);
                  failures++;
               end
               if (rsp_tlast !== want.final_result) begin
                  $error("final_result: expected %b, got %b", want.final_result, rsp_tlast);
                  failures++;
               end
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("utf8_validate_line_break_marker: mismatch");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic drain_marks();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (marks_q.size() == 0);
   endtask

   function automatic logic [7:0] any_suffix();
      return 8'($urandom_range(SUFFIX_HI, SUFFIX_LO));
   endfunction

   // one character or a piece of junk; a stream may end on any byte
   task automatic send_random_unit();
      logic [7:0]    seq [$];
      logic [7:0]    lead;
      unit_kind_type kind;
      int            pick;
      pick = $urandom_range(99);
      if (pick < 20)      kind = UNIT_ASCII;
      else if (pick < 28) kind = UNIT_CRLF;
      else if (pick < 40) kind = UNIT_TWO;
      else if (pick < 55) kind = UNIT_THREE;
      else if (pick < 68) kind = UNIT_FOUR;
      else if (pick < 80) kind = UNIT_BROKEN;
      else                kind = UNIT_NOISE;
      case (kind)
         UNIT_ASCII: begin
            if ($urandom_range(1)) seq.insert(seq.size(), 8'($urandom_range(8'h0E, 8'h08)));
            else seq.insert(seq.size(), 8'($urandom_range(8'h7F, 8'h00)));
         end
         UNIT_CRLF: begin
            seq.insert(seq.size(), CHAR_CR);
            seq.insert(seq.size(), CHAR_LF);
         end
         UNIT_TWO: begin
            if ($urandom_range(4) == 0) begin
               seq.insert(seq.size(), NEL_LEAD);
               seq.insert(seq.size(), NEL_TAIL);
            end else begin
               seq.insert(seq.size(), 8'($urandom_range(LEAD2_HI, LEAD2_LO)));
               seq.insert(seq.size(), any_suffix());
            end
         end
         UNIT_THREE: begin
            if ($urandom_range(4) == 0) begin
               seq.insert(seq.size(), LSPS_LEAD);
               seq.insert(seq.size(), LSPS_MID);
               seq.insert(seq.size(), $urandom_range(1) ? LS_TAIL : PS_TAIL);
            end else begin
               lead = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
               seq.insert(seq.size(), lead);
               if (lead == LEAD_E0)
                  seq.insert(seq.size(), 8'($urandom_range(SUFFIX_HI, ED_BAD_LO)));
               else if (lead == LEAD_ED)
                  seq.insert(seq.size(), 8'($urandom_range(E0_BAD_HI, SUFFIX_LO)));
               else seq.insert(seq.size(), any_suffix());
               seq.insert(seq.size(), any_suffix());
            end
         end
         UNIT_FOUR: begin
            lead = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
            seq.insert(seq.size(), lead);
            if (lead == LEAD_F0)
               seq.insert(seq.size(), 8'($urandom_range(SUFFIX_HI, F4_BAD_LO)));
            else if (lead == LEAD_F4)
               seq.insert(seq.size(), 8'($urandom_range(F0_BAD_HI, SUFFIX_LO)));
            else seq.insert(seq.size(), any_suffix());
            seq.insert(seq.size(), any_suffix());
            seq.insert(seq.size(), any_suffix());
         end
         UNIT_BROKEN: begin
            // overlong, surrogate or out of range seconds, or a lead with a bad or short tail
            if ($urandom_range(1)) begin
               case ($urandom_range(3))
                  0: seq.insert(seq.size(), LEAD_E0);
                  1: seq.insert(seq.size(), LEAD_ED);
                  2: seq.insert(seq.size(), LEAD_F0);
                  default: seq.insert(seq.size(), LEAD_F4);
               endcase
               seq.insert(seq.size(), any_suffix());
               seq.insert(seq.size(), any_suffix());
            end else begin
               seq.insert(seq.size(), 8'($urandom_range(8'hFF, LEAD_LO)));
               repeat ($urandom_range(3))
                  seq.insert(seq.size(), 8'($urandom_range(8'hFF, 8'h00)));
            end
         end
         default: begin
            repeat ($urandom_range(4, 1))
               seq.insert(seq.size(), 8'($urandom_range(8'hFF, 8'h00)));
         end
      endcase
      foreach (seq[i]) send_byte(seq[i], $urandom_range(23) == 0);
   endtask

   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      int stop_at;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_unit();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) send_byte(dir_table[i].data, dir_table[i].eot);
      drain_marks();

      run_random(280, 0, 0);

      // long receiver hold-off while the sender keeps offering bytes
      hold_requests++;
      run_random(40, 0, 0);
      drain_marks();

      run_random(280, 78, 0);
      run_random(280, 0, 78);
      run_random(250, 37, 37);

      // a final CR keeps its break mark and flushes the held byte
      send_byte(CHAR_CR, 1'b1);
      drain_marks();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (marks_q.size() != 0) begin
         $error("%0d expected transactions never arrived", marks_q.size());
         failures++;
      end
      $display("%0d bytes in %0d streams, %0d results checked over four idle/stall mixes",
               bytes_taken, streams_taken, results_checked);
      $display("%0d line breaks and %0d non-final marks expected, %0d failures",
               breaks_seen, nonfinal_seen, failures);
      if (failures == 0) begin
         $display("utf8_validate_line_break_marker: match");
      end else begin
         $display("utf8_validate_line_break_marker: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/uvlb_pkg.sv
sv/uvlb_classify.sv
sv/uvlb_rsp_fifo.sv
sv/utf8_validate_line_break_marker.sv
verif/utf8_validate_line_break_marker_tb.sv
